// ----- hdl/wcwm_pkg.sv -----
`default_nettype none
package wcwm_pkg;

	localparam int MAX_WORDS    = 16;
	localparam int MAX_WORD_LEN = 8;
	localparam int MAX_TEXT     = 65536;

	// width of one sliding word count
	localparam int CNT_W = 8;

	typedef enum logic [1:0] {
		CMD_DICT  = 2'd0,
		CMD_START = 2'd1,
		CMD_TEXT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_WORD_LEN   = 2'd0,
		REG_WORD_COUNT = 2'd1
	} reg_idx_t;

endpackage
`default_nettype wire

// ----- hdl/wcwm_ram.sv -----
`default_nettype none
module wcwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/word_concatenation_window_matcher.sv -----
`default_nettype none
// Streaming matcher for concatenations of all dictionary words. Load the
// dictionary with command 0 items (one character each), set word_len and
// word_count over the configuration port, then send a start item (command 1)
// and the text bytes (command 2). For every start position where word_count
// words of word_len bytes follow back to back, together forming exactly the
// dictionary multiset, one match_start item is delivered, in increasing
// position order. Dictionary, text and ignored items are taken one per clock
// while in_stall is low. After a start item the expected counts are built by
// walking the dictionary slots in use through the single dictionary compare
// bank, and no item is accepted during that walk. Text bytes flow at one per
// cycle when not stalled: the per-phase window counts live in one RAM row per
// phase that is read at acceptance and written back in the next cycle, with
// the row just written forwarded to a following byte of the same phase. The
// word history also lives in a RAM. Positions stop at MAX_TEXT bytes; later
// bytes are dropped without result. A text byte's result is registered in
// stage 1 and then in the output queue.
module word_concatenation_window_matcher #(
	parameter int MAX_WORDS    = wcwm_pkg::MAX_WORDS,
	parameter int MAX_WORD_LEN = wcwm_pkg::MAX_WORD_LEN,
	parameter int MAX_TEXT     = wcwm_pkg::MAX_TEXT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [3:0]  word_slot,
	input  wire logic [2:0]  char_index,
	input  wire logic [7:0]  byte_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      match_start
);

	localparam int KW  = 8 * MAX_WORD_LEN;
	localparam int IDW = $clog2(MAX_WORDS + 1);
	localparam int SW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int LPW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int H   = MAX_WORDS * MAX_WORD_LEN;
	localparam int HW  = (H > 1) ? $clog2(H) : 1;
	localparam int AW  = HW + 1;
	localparam int PW  = $clog2(MAX_TEXT + 1);
	localparam int XW  = (PW > AW) ? PW : AW;
	localparam int CW  = wcwm_pkg::CNT_W;
	localparam int RW  = CW * MAX_WORDS;
	localparam logic [IDW-1:0] NONE_ID = IDW'(MAX_WORDS);

	// configuration
	logic [3:0] word_len_q;
	logic [4:0] word_count_q;
	logic [3:0] d;
	logic [4:0] n;

	// dictionary and text state
	logic [KW-1:0]  dict_q [MAX_WORDS];
	logic [KW-1:0]  recent_q;
	logic [PW-1:0]  tp_q;
	logic [HW-1:0]  ptr_q;
	logic [LPW-1:0] res_q [MAX_WORD_LEN];
	logic [H-1:0]   hvalid_q;
	logic [MAX_WORD_LEN-1:0] cvalid_q;
	logic [CW-1:0]  exp_q [MAX_WORDS];
	logic           busy_q;
	logic [IDW-1:0] sweep_q;

	// stage 1
	logic           v_s1;
	logic [LPW-1:0] ph_s1;
	logic [IDW-1:0] w_s1;
	logic           oldv_s1;
	logic           emit_s1;
	logic           rowv_s1;
	logic [15:0]    ms_s1;

	// row forwarding
	logic           wb_v_q;
	logic [LPW-1:0] wb_ph_q;
	logic [RW-1:0]  wb_row_q;

	// output queue
	logic [15:0] ob_q [2];
	logic [1:0]  cnt_q;

	// combinational
	logic           acc, start_acc, dict_acc, tx, sat, has_q, use_old, may_emit;
	logic [KW-1:0]  recent_n, rev, cur, key;
	logic [IDW-1:0] id;
	logic [PW-1:0]  pn;
	logic [XW-1:0]  q_x, nd_x, dx;
	logic [HW-1:0]  ptr_n, widx, oidx;
	logic [AW-1:0]  t1, t2, nd_a;
	logic [LPW-1:0] res_n [MAX_WORD_LEN];
	logic [LPW-1:0] ph;
	logic [3:0]     dm1;
	logic [RW-1:0]  base, newrow, crd;
	logic [IDW-1:0] hrd;
	logic           match_ok, push, pop, cwe;
	logic [2:0]     room;
	logic [6:0]     shamt;

	assign cfg_ready = 1'b1;

	// clamp the registers to their working range
	always_comb begin
		if (word_len_q == 4'd0) begin
			d = 4'd1;
		end else if (int'(word_len_q) > MAX_WORD_LEN) begin
			d = 4'(MAX_WORD_LEN);
		end else begin
			d = word_len_q;
		end
		if (word_count_q == 5'd0) begin
			n = 5'd1;
		end else if (int'(word_count_q) > MAX_WORDS) begin
			n = 5'(MAX_WORDS);
		end else begin
			n = word_count_q;
		end
	end

	// handshake
	always_comb begin
		pop  = (cnt_q != 2'd0) && !out_stall;
		// leave room for the item in stage 1 and one more behind it
		room = 3'(cnt_q) - 3'(pop) + 3'(v_s1);
		in_stall  = busy_q || (room >= 3'd2);
		acc       = in_valid && !in_stall;
		start_acc = acc && (command == wcwm_pkg::CMD_START);
		dict_acc  = acc && (command == wcwm_pkg::CMD_DICT)
			&& (int'(word_slot) < MAX_WORDS) && (int'(char_index) < MAX_WORD_LEN);
		sat       = (tp_q >= PW'(MAX_TEXT));
		tx        = acc && (command == wcwm_pkg::CMD_TEXT) && !sat;
	end

	// span of the last d bytes, first character in the low byte
	always_comb begin
		recent_n = KW'({recent_q, byte_value});
		for (int k = 0; k < MAX_WORD_LEN; k++) begin
			rev[8*k +: 8] = recent_n[8*(MAX_WORD_LEN-1-k) +: 8];
		end
		shamt = {1'b0, 3'(4'(MAX_WORD_LEN) - d), 3'b000};
		cur   = rev >> shamt;
	end

	// dictionary compare bank, lowest equal slot wins
	always_comb begin
		key = busy_q ? dict_q[sweep_q[SW-1:0]] : cur;
		id  = NONE_ID;
		for (int s = MAX_WORDS - 1; s >= 0; s--) begin
			logic eq;
			eq = (s < int'(n));
			for (int k = 0; k < MAX_WORD_LEN; k++) begin
				if ((k < int'(d)) && (dict_q[s][8*k +: 8] != key[8*k +: 8])) begin
					eq = 1'b0;
				end
			end
			if (eq) begin
				id = IDW'(s);
			end
		end
	end

	// positions, phase and history addresses
	always_comb begin
		pn       = tp_q + PW'(1);
		dx       = XW'(d);
		nd_x     = XW'(n) * dx;
		has_q    = (XW'(pn) >= dx);
		q_x      = XW'(pn) - dx;
		use_old  = (q_x >= nd_x);
		may_emit = (q_x >= nd_x - dx);

		ptr_n = (ptr_q == HW'(H - 1)) ? '0 : ptr_q + HW'(1);
		t1    = AW'(ptr_n) + AW'(H) - AW'(d);
		widx  = (t1 >= AW'(H)) ? HW'(t1 - AW'(H)) : HW'(t1);
		nd_a  = AW'(n) * AW'(d);
		t2    = AW'(widx) + AW'(H) - nd_a;
		oidx  = (t2 >= AW'(H)) ? HW'(t2 - AW'(H)) : HW'(t2);

		for (int k = 0; k < MAX_WORD_LEN; k++) begin
			res_n[k] = (res_q[k] == LPW'(k)) ? '0 : res_q[k] + LPW'(1);
		end
		dm1 = d - 4'd1;
		// the text position and its span start share one residue mod d
		ph  = res_n[dm1[LPW-1:0]];
	end

	wcwm_ram #(
		.WIDTH (IDW),
		.DEPTH (H)
	) u_hist (
		.clk   (clk),
		.we    (tx && has_q),
		.waddr (widx),
		.wdata (id),
		.raddr (oidx),
		.rdata (hrd)
	);

	wcwm_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_WORD_LEN)
	) u_counts (
		.clk   (clk),
		.we    (cwe),
		.waddr (ph_s1),
		.wdata (newrow),
		.raddr (ph),
		.rdata (crd)
	);

	// stage 1: update the phase row and compare it with the expected counts
	always_comb begin
		if (wb_v_q && (wb_ph_q == ph_s1)) begin
			base = wb_row_q;
		end else if (rowv_s1) begin
			base = crd;
		end else begin
			base = '0;
		end
		match_ok = 1'b1;
		for (int s = 0; s < MAX_WORDS; s++) begin
			logic [CW-1:0] c;
			c = base[CW*s +: CW];
			if (oldv_s1 && (hrd == IDW'(s)) && (c != '0)) begin
				c = c - CW'(1);
			end
			if ((w_s1 == IDW'(s)) && (c != '1)) begin
				c = c + CW'(1);
			end
			newrow[CW*s +: CW] = c;
			if (c != exp_q[s]) begin
				match_ok = 1'b0;
			end
		end
		push = v_s1 && emit_s1 && match_ok;
		// a start item in this cycle drops the pending write-back
		cwe  = v_s1 && !start_acc;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q   <= 4'd1;
			word_count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == wcwm_pkg::REG_WORD_LEN) begin
				word_len_q <= cfg_data[3:0];
			end else if (cfg_index == wcwm_pkg::REG_WORD_COUNT) begin
				word_count_q <= cfg_data;
			end
		end
	end

	// dictionary
	always_ff @(posedge clk) begin
		if (dict_acc) begin
			dict_q[SW'(word_slot)][8*char_index +: 8] <= byte_value;
		end
	end

	// text control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			tp_q     <= '0;
			ptr_q    <= '0;
			hvalid_q <= '0;
			cvalid_q <= '0;
			busy_q   <= 1'b0;
			sweep_q  <= '0;
			v_s1     <= 1'b0;
			wb_v_q   <= 1'b0;
			cnt_q    <= 2'd0;
			for (int k = 0; k < MAX_WORD_LEN; k++) begin
				res_q[k] <= '0;
			end
			for (int s = 0; s < MAX_WORDS; s++) begin
				exp_q[s] <= '0;
			end
		end else begin
			v_s1   <= tx && has_q;
			wb_v_q <= cwe;
			if (cwe) begin
				cvalid_q[ph_s1] <= 1'b1;
			end
			if (start_acc) begin
				recent_q <= '0;
				tp_q     <= '0;
				ptr_q    <= '0;
				hvalid_q <= '0;
				cvalid_q <= '0;
				busy_q   <= 1'b1;
				sweep_q  <= '0;
				for (int k = 0; k < MAX_WORD_LEN; k++) begin
					res_q[k] <= '0;
				end
				for (int s = 0; s < MAX_WORDS; s++) begin
					exp_q[s] <= '0;
				end
			end else if (tx) begin
				recent_q <= recent_n;
				tp_q     <= pn;
				ptr_q    <= ptr_n;
				res_q    <= res_n;
				if (has_q) begin
					hvalid_q[widx] <= 1'b1;
				end
			end
			// walk the slots in use and count each word under its first slot
			if (busy_q) begin
				if (id != NONE_ID) begin
					exp_q[id[SW-1:0]] <= exp_q[id[SW-1:0]] + CW'(1);
				end
				sweep_q <= sweep_q + IDW'(1);
				if (6'(sweep_q) + 6'd1 == 6'(n)) begin
					busy_q <= 1'b0;
				end
			end
			cnt_q <= cnt_q - 2'(pop) + 2'(push);
		end
	end

	// stage 1 payload, forwarded row and output queue
	always_ff @(posedge clk) begin
		ph_s1    <= ph;
		w_s1     <= id;
		oldv_s1  <= use_old && hvalid_q[oidx];
		emit_s1  <= may_emit;
		rowv_s1  <= cvalid_q[ph];
		ms_s1    <= 16'(q_x - (nd_x - dx));
		wb_ph_q  <= ph_s1;
		wb_row_q <= newrow;
		// head takes the new item when the queue drains to empty, else advance
		if (push && (cnt_q == 2'(pop))) begin
			ob_q[0] <= ms_s1;
		end else if (pop) begin
			ob_q[0] <= ob_q[1];
		end
		if (push && (cnt_q - 2'(pop) == 2'd1)) begin
			ob_q[1] <= ms_s1;
		end
	end

	assign out_valid   = (cnt_q != 2'd0);
	assign match_start = ob_q[0];

endmodule
`default_nettype wire
